// ===== sv/lbp_pkg.sv =====
package lbp_pkg;

  // Field widths fixed by the interface
  localparam int SUM_W     = 29;
  localparam int NODE_W    = 6;
  localparam int IDX_W     = 5;
  localparam int LIMIT_W   = 24;
  localparam int PEAK_W    = 24;
  localparam int CMD_W     = 2;
  localparam int KIND_W    = 2;
  localparam int CFG_IDX_W = 3;
  localparam int REM_W     = NODE_W;
  localparam int DIV_CNT_W = 5;

  // Input commands
  localparam logic [CMD_W-1:0] CMD_NODE_COUNT   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLOSE_COUNTS = 2'd1;
  localparam logic [CMD_W-1:0] CMD_POINT_LABEL  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CLOSE_POINTS = 2'd3;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_DECISION = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SHARE    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_OUTSIDE  = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BALANCE_ENABLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AVERAGE_LIMIT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PEAK_LIMIT     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OWN_RANK       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NODE_TOTAL     = 3'd4;

endpackage

// ===== sv/load_balance_partitioner.sv =====
// Channel  | Direction | Transfer when          | Payload
// in_      | input     | in_valid & in_ready    | command, value, present
// out_     | output    | out_valid & out_ready  | kind .. last (ten fields)
// cfg_     | input     | cfg_we                 | cfg_index, cfg_data
//
// Close counts runs the bit-serial divider (one quotient bit a cycle), then
// emits its results: the decision and, when rebalancing, one share per node;
// each result waits on the output register.
// Reset clears statistics, range and flags and loads the register defaults.
// A stalled output holds the result register and keeps in_ready low.
module load_balance_partitioner
  import lbp_pkg::*;
#(
  parameter int MAX_NODES  = 32,
  parameter int COUNT_BITS = 24
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [CMD_W-1:0]     in_command,
  input  logic [SUM_W-1:0]     in_value,
  input  logic                 in_present,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [KIND_W-1:0]    out_kind,
  output logic [IDX_W-1:0]     out_node_index,
  output logic [SUM_W-1:0]     out_amount,
  output logic [SUM_W-1:0]     out_start_offset,
  output logic [PEAK_W-1:0]    out_peak,
  output logic [NODE_W-1:0]    out_involved,
  output logic                 out_rebalance,
  output logic                 out_spread_flag,
  output logic                 out_overload_flag,
  output logic                 out_last,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [LIMIT_W-1:0]   cfg_data
);

  localparam int CW = (COUNT_BITS < SUM_W) ? COUNT_BITS : SUM_W;
  localparam logic [CW-1:0] CMAX = '1;
  localparam logic [COUNT_BITS-1:0] OMAX = '1;
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(SUM_W - 1);

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_DEC, S_SHARE} state_t;

  state_t                  state_r;
  logic                    bal_en_r;
  logic [LIMIT_W-1:0]      avg_lim_r;
  logic [LIMIT_W-1:0]      peak_lim_r;
  logic [IDX_W-1:0]        rank_r;
  logic [NODE_W-1:0]       ntot_r;

  logic [SUM_W-1:0]        load_sum_r;
  logic [CW-1:0]           load_peak_r;
  logic [NODE_W-1:0]       busy_r;
  logic                    bal_act_r;
  logic [SUM_W-1:0]        range_first_r;
  logic [SUM_W-1:0]        range_last_r;
  logic [COUNT_BITS-1:0]   outside_r;
  logic [REM_W-1:0]        rem_r;
  logic [DIV_CNT_W-1:0]    div_cnt_r;
  logic [NODE_W-1:0]       share_idx_r;
  logic [SUM_W-1:0]        share_q_r;
  logic [REM_W-1:0]        share_rem_r;

  logic                    out_valid_r;
  logic [KIND_W-1:0]       out_kind_r;
  logic [IDX_W-1:0]        out_idx_r;
  logic [SUM_W-1:0]        out_amount_r;
  logic [SUM_W-1:0]        out_start_r;
  logic [PEAK_W-1:0]       out_peak_r;
  logic [NODE_W-1:0]       out_inv_r;
  logic                    out_reb_r;
  logic                    out_sp_r;
  logic                    out_ov_r;
  logic                    out_last_r;

  logic                    out_free;
  logic                    out_load;
  logic                    in_xfer;
  logic [NODE_W-1:0]       n_eff;
  logic [NODE_W-1:0]       rank_eff;
  logic [CW-1:0]           cnt_clip;
  logic [SUM_W:0]          sum_wide;
  logic [SUM_W-1:0]        sum_nxt;
  logic [REM_W:0]          div_shift;
  logic                    div_ge;
  logic [REM_W:0]          div_sub;
  logic [CW-1:0]           avg_sat;
  logic                    spread;
  logic                    overload;
  logic                    reb;
  logic [REM_W:0]          rsum;
  logic                    carry;
  logic [REM_W:0]          rsub;
  logic [REM_W-1:0]        share_rem_nxt;
  logic [SUM_W-1:0]        share_q_nxt;
  logic                    share_last;
  logic                    outside_hit;

  // Handshake
  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE) && out_free;
  assign in_xfer  = in_valid && in_ready;

  // A new result enters the output register this cycle
  assign out_load = (in_xfer && (in_command == CMD_CLOSE_POINTS)) ||
                    (((state_r == S_DEC) || (state_r == S_SHARE)) && out_free);

  // Effective node total and rank
  always_comb begin
    if (ntot_r == '0) begin
      n_eff = NODE_W'(1);
    end else if (ntot_r > NODE_W'(MAX_NODES)) begin
      n_eff = NODE_W'(MAX_NODES);
    end else begin
      n_eff = ntot_r;
    end
    rank_eff = ({1'b0, rank_r} >= n_eff) ? n_eff - NODE_W'(1) : {1'b0, rank_r};
  end

  // Running statistics update, saturating
  assign cnt_clip = (in_value > SUM_W'(CMAX)) ? CMAX : in_value[CW-1:0];
  assign sum_wide = {1'b0, load_sum_r} + (SUM_W + 1)'(cnt_clip);
  assign sum_nxt  = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];

  // Restoring divider step: one quotient bit a cycle
  assign div_shift = {rem_r, load_sum_r[SUM_W-1]};
  assign div_ge    = div_shift >= {1'b0, n_eff};
  assign div_sub   = div_shift - {1'b0, n_eff};

  // Decision from quotient held in load_sum_r
  assign avg_sat  = (load_sum_r > SUM_W'(CMAX)) ? CMAX : load_sum_r[CW-1:0];
  assign spread   = SUM_W'(avg_sat) >= SUM_W'(avg_lim_r);
  assign overload = SUM_W'(load_peak_r) >= SUM_W'(peak_lim_r);
  assign reb      = bal_en_r && (spread || overload);

  // Next share boundary: add quotient and remainder, carry on wrap
  assign rsum          = {1'b0, share_rem_r} + {1'b0, rem_r};
  assign carry         = rsum >= {1'b0, n_eff};
  assign rsub          = rsum - {1'b0, n_eff};
  assign share_rem_nxt = carry ? rsub[REM_W-1:0] : rsum[REM_W-1:0];
  assign share_q_nxt   = share_q_r + load_sum_r + SUM_W'(carry);
  assign share_last    = share_idx_r == n_eff - NODE_W'(1);

  // Label outside this rank's range
  assign outside_hit = in_present && bal_act_r &&
                       ((in_value < range_first_r) || (in_value >= range_last_r));

  // Control, state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      bal_en_r      <= 1'b0;
      avg_lim_r     <= '1;
      peak_lim_r    <= '1;
      rank_r        <= '0;
      ntot_r        <= NODE_W'(1);
      load_sum_r    <= '0;
      load_peak_r   <= '0;
      busy_r        <= '0;
      bal_act_r     <= 1'b0;
      range_first_r <= '0;
      range_last_r  <= '0;
      outside_r     <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      // Configuration writes
      if (cfg_we) begin
        case (cfg_index)
          REG_BALANCE_ENABLE: bal_en_r   <= cfg_data[0];
          REG_AVERAGE_LIMIT:  avg_lim_r  <= cfg_data;
          REG_PEAK_LIMIT:     peak_lim_r <= cfg_data;
          REG_OWN_RANK:       rank_r     <= cfg_data[IDX_W-1:0];
          REG_NODE_TOTAL:     ntot_r     <= cfg_data[NODE_W-1:0];
          default: ;
        endcase
      end

      // Load a new result, or drop the one just transferred
      out_valid_r <= out_load || (out_valid_r && !out_ready);

      case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            case (in_command)
              CMD_NODE_COUNT: begin
                load_sum_r <= sum_nxt;
                if (cnt_clip > load_peak_r) begin
                  load_peak_r <= cnt_clip;
                end
                if (cnt_clip != '0 && busy_r != '1) begin
                  busy_r <= busy_r + NODE_W'(1);
                end
              end
              CMD_CLOSE_COUNTS: begin
                rem_r     <= '0;
                div_cnt_r <= '0;
                state_r   <= S_DIV;
              end
              CMD_POINT_LABEL: begin
                if (outside_hit && outside_r != OMAX) begin
                  outside_r <= outside_r + COUNT_BITS'(1);
                end
              end
              CMD_CLOSE_POINTS: begin
                out_kind_r   <= KIND_OUTSIDE;
                out_idx_r    <= '0;
                out_amount_r <= bal_act_r ? SUM_W'(outside_r) : '0;
                out_start_r  <= '0;
                out_peak_r   <= '0;
                out_inv_r    <= '0;
                out_reb_r    <= 1'b0;
                out_sp_r     <= 1'b0;
                out_ov_r     <= 1'b0;
                out_last_r   <= 1'b1;
                outside_r    <= '0;
              end
              default: ;
            endcase
          end
        end
        S_DIV: begin
          // Shift the dividend up, quotient bits enter at the bottom
          rem_r      <= div_ge ? div_sub[REM_W-1:0] : div_shift[REM_W-1:0];
          load_sum_r <= {load_sum_r[SUM_W-2:0], div_ge};
          div_cnt_r  <= div_cnt_r + DIV_CNT_W'(1);
          if (div_cnt_r == DIV_LAST) begin
            state_r <= S_DEC;
          end
        end
        S_DEC: begin
          if (out_free) begin
            out_kind_r   <= KIND_DECISION;
            out_idx_r    <= '0;
            out_amount_r <= SUM_W'(avg_sat);
            out_start_r  <= '0;
            out_peak_r   <= PEAK_W'(load_peak_r);
            out_inv_r    <= busy_r;
            out_reb_r    <= reb;
            out_sp_r     <= spread;
            out_ov_r     <= overload;
            out_last_r   <= !reb;
            bal_act_r    <= reb;
            outside_r    <= '0;
            load_peak_r  <= '0;
            busy_r       <= '0;
            share_idx_r  <= '0;
            share_q_r    <= '0;
            share_rem_r  <= '0;
            if (reb) begin
              state_r <= S_SHARE;
            end else begin
              load_sum_r <= '0;
              state_r    <= S_IDLE;
            end
          end
        end
        S_SHARE: begin
          if (out_free) begin
            out_kind_r   <= KIND_SHARE;
            out_idx_r    <= share_idx_r[IDX_W-1:0];
            out_amount_r <= load_sum_r + SUM_W'(carry);
            out_start_r  <= share_q_r;
            out_peak_r   <= '0;
            out_inv_r    <= '0;
            out_reb_r    <= 1'b0;
            out_sp_r     <= 1'b0;
            out_ov_r     <= 1'b0;
            out_last_r   <= share_last;
            if (share_idx_r == rank_eff) begin
              range_first_r <= share_q_r;
              range_last_r  <= share_q_nxt;
            end
            share_idx_r <= share_idx_r + NODE_W'(1);
            share_q_r   <= share_q_nxt;
            share_rem_r <= share_rem_nxt;
            if (share_last) begin
              load_sum_r <= '0;
              state_r    <= S_IDLE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Ports
  assign out_valid         = out_valid_r;
  assign out_kind          = out_kind_r;
  assign out_node_index    = out_idx_r;
  assign out_amount        = out_amount_r;
  assign out_start_offset  = out_start_r;
  assign out_peak          = out_peak_r;
  assign out_involved      = out_inv_r;
  assign out_rebalance     = out_reb_r;
  assign out_spread_flag   = out_sp_r;
  assign out_overload_flag = out_ov_r;
  assign out_last          = out_last_r;

  // Checks
  a_share_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SHARE |-> share_idx_r < n_eff)
    else $error("share index beyond node total");

  a_share_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SHARE |-> share_rem_r < n_eff && rem_r < n_eff)
    else $error("share remainder not below node total");

  a_close_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_command == CMD_CLOSE_COUNTS |=> state_r == S_DIV)
    else $error("close counts did not start the divider");

  a_share_needs_partition: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_kind_r == KIND_SHARE |-> bal_act_r)
    else $error("share result without an active partition");

endmodule

// ===== test/load_balance_partitioner_test.sv =====
module load_balance_partitioner_test;
  import lbp_pkg::*;

  localparam int              NODES_MAX     = 32;
  localparam int              BUSY_MAX      = 63;
  localparam longint unsigned LOAD_CEIL     = 64'hFF_FFFF;
  localparam longint unsigned SUM_MAX       = 64'h1FFF_FFFF;
  localparam int              SETTLE_CYCLES = 40;
  localparam int              RANDOM_ITEMS  = 410;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [IDX_W-1:0]  node;
    logic [SUM_W-1:0]  amount;
    logic [SUM_W-1:0]  offset;
    logic [PEAK_W-1:0] peak;
    logic [NODE_W-1:0] involved;
    logic              reb;
    logic              spread;
    logic              overload;
    logic              last;
  } partition_result_t;

  typedef struct {
    bit                   is_reg;
    logic [CFG_IDX_W-1:0] reg_idx;
    longint unsigned      reg_val;
    logic [CMD_W-1:0]     cmd;
    logic [SUM_W-1:0]     val;
    logic                 pres;
    bit                   fixed;
    partition_result_t    want;
  } stim_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [CMD_W-1:0]     in_command = CMD_NODE_COUNT;
  logic [SUM_W-1:0]     in_value = '0;
  logic                 in_present = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [KIND_W-1:0]    out_kind;
  logic [IDX_W-1:0]     out_node_index;
  logic [SUM_W-1:0]     out_amount;
  logic [SUM_W-1:0]     out_start_offset;
  logic [PEAK_W-1:0]    out_peak;
  logic [NODE_W-1:0]    out_involved;
  logic                 out_rebalance;
  logic                 out_spread_flag;
  logic                 out_overload_flag;
  logic                 out_last;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [LIMIT_W-1:0]   cfg_data = '0;

  // Register mirror, reset values
  bit              cfg_balance  = 1'b0;
  longint unsigned cfg_avg_lim  = LOAD_CEIL;
  longint unsigned cfg_peak_lim = LOAD_CEIL;
  longint unsigned cfg_rank     = 0;
  longint unsigned cfg_nodes    = 1;

  // Partition state as the block should hold it
  longint unsigned work_sum = 0;
  longint unsigned work_peak = 0;
  longint unsigned busy_count = 0;
  bit              partition_live = 1'b0;
  longint unsigned own_first = 0;
  longint unsigned own_end = 0;
  longint unsigned stray_labels = 0;

  partition_result_t awaited[$];
  stim_row_t         script[$];
  int                first_new;
  int                burst_left = 0;
  int                items_done = 0;
  int                failures = 0;

  load_balance_partitioner uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_command       (in_command),
    .in_value         (in_value),
    .in_present       (in_present),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_node_index   (out_node_index),
    .out_amount       (out_amount),
    .out_start_offset (out_start_offset),
    .out_peak         (out_peak),
    .out_involved     (out_involved),
    .out_rebalance    (out_rebalance),
    .out_spread_flag  (out_spread_flag),
    .out_overload_flag(out_overload_flag),
    .out_last         (out_last),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic partition_result_t make_result(
    input longint unsigned kind, node, amount, offset, peak, involved,
    input bit reb, spread, overload, last);
    partition_result_t r;
    r.kind     = kind[KIND_W-1:0];
    r.node     = node[IDX_W-1:0];
    r.amount   = amount[SUM_W-1:0];
    r.offset   = offset[SUM_W-1:0];
    r.peak     = peak[PEAK_W-1:0];
    r.involved = involved[NODE_W-1:0];
    r.reb      = reb;
    r.spread   = spread;
    r.overload = overload;
    r.last     = last;
    return r;
  endfunction

  // Advance the partition state by one item and queue the results it causes
  task automatic apply_item(input logic [CMD_W-1:0] cmd, input logic [SUM_W-1:0] val,
                            input logic pres);
    longint unsigned c, n, avg, lo, hi, rank, i;
    bit              sp, ov, reb;
    case (cmd)
      CMD_NODE_COUNT: begin
        c = (val > LOAD_CEIL) ? LOAD_CEIL : val;
        work_sum = work_sum + c;
        if (work_sum > SUM_MAX) work_sum = SUM_MAX;
        if (c > work_peak) work_peak = c;
        if (c != 0 && busy_count < BUSY_MAX) busy_count++;
      end
      CMD_CLOSE_COUNTS: begin
        n = cfg_nodes;
        if (n == 0) n = 1;
        if (n > NODES_MAX) n = NODES_MAX;
        avg = work_sum / n;
        if (avg > LOAD_CEIL) avg = LOAD_CEIL;
        sp  = (avg >= cfg_avg_lim);
        ov  = (work_peak >= cfg_peak_lim);
        reb = cfg_balance && (sp || ov);
        awaited.push_back(make_result(KIND_DECISION, 0, avg, 0, work_peak, busy_count,
                                      reb, sp, ov, !reb));
        partition_live = reb;
        stray_labels = 0;
        if (reb) begin
          rank = (cfg_rank >= n) ? n - 1 : cfg_rank;
          for (i = 0; i < n; i++) begin
            lo = (i * work_sum) / n;
            hi = ((i + 1) * work_sum) / n;
            awaited.push_back(make_result(KIND_SHARE, i, hi - lo, lo, 0, 0,
                                          1'b0, 1'b0, 1'b0, (i + 1) == n));
            if (i == rank) begin
              own_first = lo;
              own_end = hi;
            end
          end
        end
        work_sum = 0;
        work_peak = 0;
        busy_count = 0;
      end
      CMD_POINT_LABEL: begin
        if (pres && partition_live && (val < own_first || val >= own_end) &&
            stray_labels < LOAD_CEIL)
          stray_labels++;
      end
      default: begin
        awaited.push_back(make_result(KIND_OUTSIDE, 0, partition_live ? stray_labels : 0,
                                      0, 0, 0, 1'b0, 1'b0, 1'b0, 1'b1));
        stray_labels = 0;
      end
    endcase
  endtask

  // Offer one item in bursts with gaps, hold it until the transfer, then predict
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [SUM_W-1:0] val,
                           input logic pres);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 10);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid   <= 1'b1;
    in_command <= cmd;
    in_value   <= val;
    in_present <= pres;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_done++;
    first_new = awaited.size();
    apply_item(cmd, val, pres);
  endtask

  // Hold the input until every expected result has been transferred
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    burst_left = 0;
    while (awaited.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // Write one register once the block has gone quiet
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input longint unsigned data);
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data[LIMIT_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_BALANCE_ENABLE: cfg_balance  = data[0];
      REG_AVERAGE_LIMIT:  cfg_avg_lim  = data & LOAD_CEIL;
      REG_PEAK_LIMIT:     cfg_peak_lim = data & LOAD_CEIL;
      REG_OWN_RANK:       cfg_rank     = data & 64'h1F;
      REG_NODE_TOTAL:     cfg_nodes    = data & 64'h3F;
      default: ;
    endcase
  endtask

  function automatic void add_write(input logic [CFG_IDX_W-1:0] idx,
                                    input longint unsigned data);
    stim_row_t r;
    r = '{default: '0};
    r.is_reg  = 1'b1;
    r.reg_idx = idx;
    r.reg_val = data;
    script.push_back(r);
  endfunction

  function automatic void add_send(input logic [CMD_W-1:0] cmd, input logic [SUM_W-1:0] val,
                                   input logic pres);
    stim_row_t r;
    r = '{default: '0};
    r.cmd  = cmd;
    r.val  = val;
    r.pres = pres;
    script.push_back(r);
  endfunction

  function automatic void add_fixed(input logic [CMD_W-1:0] cmd, input partition_result_t want);
    stim_row_t r;
    r = '{default: '0};
    r.cmd   = cmd;
    r.fixed = 1'b1;
    r.want  = want;
    script.push_back(r);
  endfunction

  function automatic longint unsigned pick_limit();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return LOAD_CEIL;
      2:       return $urandom_range(0, 3000);
      default: return $urandom & LOAD_CEIL;
    endcase
  endfunction

  function automatic logic [SUM_W-1:0] pick_count();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return SUM_MAX[SUM_W-1:0];
      2:       return LOAD_CEIL[SUM_W-1:0];
      3:       return 29'h100_0000;
      4:       return SUM_W'($urandom);
      default: return SUM_W'($urandom_range(1, 2000));
    endcase
  endfunction

  // Aim most labels around the own range so both sides of each bound are hit
  function automatic logic [SUM_W-1:0] pick_label();
    longint unsigned lo, hi;
    if (partition_live && $urandom_range(0, 4) != 0) begin
      lo = (own_first >= 2) ? own_first - 2 : 0;
      hi = (own_end + 1 > SUM_MAX) ? SUM_MAX : own_end + 1;
      return SUM_W'($urandom_range(32'(hi), 32'(lo)));
    end
    return ($urandom_range(0, 1) == 0) ? SUM_W'($urandom) : SUM_W'($urandom_range(0, 300));
  endfunction

  // One random pass: maybe reconfigure, a count run, then a few label runs
  task automatic random_phase();
    int  len;
    bit  heavy;
    if ($urandom_range(0, 1) == 0) begin
      write_reg(REG_BALANCE_ENABLE, 64'($urandom_range(0, 3) != 0));
      write_reg(REG_AVERAGE_LIMIT, pick_limit());
      write_reg(REG_PEAK_LIMIT, pick_limit());
      write_reg(REG_OWN_RANK, ($urandom_range(0, 4) == 0) ? ($urandom & LOAD_CEIL)
                                                          : $urandom_range(0, 31));
      case ($urandom_range(0, 9))
        0:       write_reg(REG_NODE_TOTAL, 0);
        1:       write_reg(REG_NODE_TOTAL, NODES_MAX);
        2:       write_reg(REG_NODE_TOTAL, $urandom_range(33, 63));
        3:       write_reg(REG_NODE_TOTAL, $urandom & LOAD_CEIL);
        default: write_reg(REG_NODE_TOTAL, $urandom_range(1, 8));
      endcase
    end
    // stray label or close out of sequence
    if ($urandom_range(0, 7) == 0)
      send_item(($urandom_range(0, 1) == 0) ? CMD_CLOSE_POINTS : CMD_POINT_LABEL,
                SUM_W'($urandom), 1'($urandom_range(0, 1)));
    // heavy runs drive the sum and busy counters into saturation
    heavy = ($urandom_range(0, 9) == 0);
    len = heavy ? $urandom_range(66, 75) : $urandom_range(0, 10);
    repeat (len)
      send_item(CMD_NODE_COUNT,
                heavy ? (($urandom_range(0, 15) == 0) ? '0 : SUM_MAX[SUM_W-1:0]) : pick_count(),
                1'($urandom_range(0, 1)));
    send_item(CMD_CLOSE_COUNTS, SUM_W'($urandom), 1'($urandom_range(0, 1)));
    repeat ($urandom_range(0, 3)) begin
      repeat ($urandom_range(0, 12))
        send_item(CMD_POINT_LABEL, pick_label(), $urandom_range(0, 3) != 0);
      send_item(CMD_CLOSE_POINTS, SUM_W'($urandom), 1'($urandom_range(0, 1)));
    end
    if ($urandom_range(0, 9) == 0) hold_until_drained();
  endtask

  function automatic bit field_ok(input string name, input logic [63:0] want, got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  // Receiver stalls: always ready, a rotating mask, or coin tosses
  int       ready_mode = 0;
  int       mode_left = 0;
  bit [7:0] ready_mask = 8'hFF;

  always @(posedge clk) begin
    if (mode_left == 0) begin
      ready_mode = $urandom_range(0, 2);
      mode_left  = $urandom_range(16, 200);
      ready_mask = 8'($urandom) | 8'h01;
    end else begin
      mode_left--;
    end
    case (ready_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= ready_mask[0];
      default: out_ready <= 1'($urandom_range(0, 1));
    endcase
    ready_mask = {ready_mask[0], ready_mask[7:1]};
  end

  // Compare every result transfer with the oldest expectation
  always @(posedge clk) begin : result_check
    partition_result_t want;
    bit                ok;
    if (rst_n && out_valid && out_ready) begin
      if (awaited.size() == 0) begin
        $error("result transfer with nothing expected: kind %0d amount %0d",
               out_kind, out_amount);
        failures++;
      end else begin
        want = awaited.pop_front();
        ok = 1'b1;
        ok &= field_ok("kind", want.kind, out_kind);
        ok &= field_ok("node_index", want.node, out_node_index);
        ok &= field_ok("amount", want.amount, out_amount);
        ok &= field_ok("start_offset", want.offset, out_start_offset);
        ok &= field_ok("peak", want.peak, out_peak);
        ok &= field_ok("involved", want.involved, out_involved);
        ok &= field_ok("rebalance", want.reb, out_rebalance);
        ok &= field_ok("spread_flag", want.spread, out_spread_flag);
        ok &= field_ok("overload_flag", want.overload, out_overload_flag);
        ok &= field_ok("last", want.last, out_last);
        if (!ok) failures++;
      end
    end
  end

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    // Reset defaults: nothing to balance, saturating averages
    add_fixed(CMD_CLOSE_POINTS, make_result(KIND_OUTSIDE, 0, 0, 0, 0, 0,
                                            1'b0, 1'b0, 1'b0, 1'b1));
    add_fixed(CMD_CLOSE_COUNTS, make_result(KIND_DECISION, 0, 0, 0, 0, 0,
                                            1'b0, 1'b0, 1'b0, 1'b1));
    add_send(CMD_NODE_COUNT, SUM_MAX[SUM_W-1:0], 1'b1);
    add_send(CMD_NODE_COUNT, SUM_MAX[SUM_W-1:0], 1'b0);
    add_fixed(CMD_CLOSE_COUNTS,
              make_result(KIND_DECISION, 0, LOAD_CEIL, 0, LOAD_CEIL, 2,
                          1'b0, 1'b1, 1'b1, 1'b1));
    add_send(CMD_POINT_LABEL, 29'd5, 1'b1);
    add_fixed(CMD_CLOSE_POINTS, make_result(KIND_OUTSIDE, 0, 0, 0, 0, 0,
                                            1'b0, 1'b0, 1'b0, 1'b1));
    // Spreading on average, rank above node total
    add_write(REG_BALANCE_ENABLE, 1);
    add_write(REG_AVERAGE_LIMIT, 0);
    add_write(REG_OWN_RANK, 7);
    add_write(REG_NODE_TOTAL, 4);
    add_send(CMD_NODE_COUNT, 29'd0, 1'b0);
    add_send(CMD_NODE_COUNT, 29'd100, 1'b1);
    add_send(CMD_NODE_COUNT, 29'd7, 1'b0);
    add_send(CMD_CLOSE_COUNTS, 29'd0, 1'b0);
    add_send(CMD_POINT_LABEL, 29'd0, 1'b1);
    add_send(CMD_POINT_LABEL, SUM_MAX[SUM_W-1:0], 1'b0);
    add_send(CMD_POINT_LABEL, SUM_MAX[SUM_W-1:0], 1'b1);
    add_send(CMD_POINT_LABEL, 29'd26, 1'b1);
    add_send(CMD_CLOSE_POINTS, 29'd0, 1'b1);
    // Node total zero, overload on peak
    add_write(REG_NODE_TOTAL, 0);
    add_write(REG_AVERAGE_LIMIT, LOAD_CEIL);
    add_write(REG_PEAK_LIMIT, 0);
    add_write(REG_OWN_RANK, 0);
    add_send(CMD_NODE_COUNT, 29'd3, 1'b1);
    add_send(CMD_CLOSE_COUNTS, 29'd0, 1'b1);
    add_send(CMD_POINT_LABEL, 29'd2, 1'b1);
    add_send(CMD_POINT_LABEL, 29'd3, 1'b1);
    add_send(CMD_CLOSE_POINTS, 29'd0, 1'b0);
    // Node total above the maximum, last rank
    add_write(REG_NODE_TOTAL, 63);
    add_write(REG_PEAK_LIMIT, 24'h80_0000);
    add_write(REG_OWN_RANK, 31);
    add_send(CMD_NODE_COUNT, 29'h80_0000, 1'b0);
    add_send(CMD_CLOSE_COUNTS, 29'd0, 1'b0);
    add_send(CMD_POINT_LABEL, 29'h7F_FFFF, 1'b1);
    add_send(CMD_CLOSE_POINTS, 29'd0, 1'b1);
    // Balancing off: close with no counts, then close points with no partition
    add_write(REG_BALANCE_ENABLE, 0);
    add_fixed(CMD_CLOSE_COUNTS, make_result(KIND_DECISION, 0, 0, 0, 0, 0,
                                            1'b0, 1'b0, 1'b0, 1'b1));
    add_fixed(CMD_CLOSE_POINTS, make_result(KIND_OUTSIDE, 0, 0, 0, 0, 0,
                                            1'b0, 1'b0, 1'b0, 1'b1));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Walk the directed table
    foreach (script[r]) begin
      if (script[r].is_reg) begin
        write_reg(script[r].reg_idx, script[r].reg_val);
      end else begin
        send_item(script[r].cmd, script[r].val, script[r].pres);
        if (script[r].fixed) awaited[first_new] = script[r].want;
      end
    end

    // Random sequences until enough items have been sent
    items_done = 0;
    while (items_done < RANDOM_ITEMS) random_phase();

    // Drain, then let the block settle before the verdict
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (awaited.size() != 0) begin
      $error("%0d expected results never arrived", awaited.size());
      failures++;
    end
    if (failures == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
